// File: rtl/rfp_pkg.sv
// ----------------------------------------------------------------------------
// rfp_pkg - radar frame parser shared types
// Frame status codes, result word layout and frame delimiter constants.
// ----------------------------------------------------------------------------
package rfp_pkg;

  localparam int COUNT_W = 17;
  localparam int LEN_W   = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // header and trailer delimiters, first byte on the wire first
  localparam logic [7:0] HEAD_BYTES [3] = '{8'hFF, 8'hEE, 8'hDD};
  localparam logic [7:0] TAIL_BYTES [3] = '{8'hDD, 8'hEE, 8'hFF};

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    BAD_HEADER  = 2'd1,
    BAD_LENGTH  = 2'd2,
    BAD_TRAILER = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [7:0] pos_x;
    logic signed [7:0] pos_y;
    status_t           frame_status;
  } result_t;

endpackage

// File: rtl/rfp_in_if.sv
// ----------------------------------------------------------------------------
// rfp_in_if - received byte channel
// Valid/ready channel carrying one serial byte and its line end flag.
// ----------------------------------------------------------------------------
interface rfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       line_end;

  modport source (output valid, output rx_byte, output line_end, input ready);
  modport sink   (input valid, input rx_byte, input line_end, output ready);
endinterface

// File: rtl/rfp_out_if.sv
// ----------------------------------------------------------------------------
// rfp_out_if - frame result channel
// Valid/ready channel carrying the held position and frame status.
// ----------------------------------------------------------------------------
interface rfp_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] pos_x;
  logic signed [7:0] pos_y;
  logic [1:0]        frame_status;

  modport source (output valid, output pos_x, output pos_y, output frame_status,
                  input ready);
  modport sink   (input valid, input pos_x, input pos_y, input frame_status,
                  output ready);
endinterface

// File: rtl/rfp_core.sv
// ----------------------------------------------------------------------------
// rfp_core - frame checker and position holder
// Updates the per-line counters and checks on every taken byte and forms the
// result word on the byte that ends the line.
// ----------------------------------------------------------------------------
module rfp_core import rfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] rx_byte,
  input  logic       line_end,
  output logic       fire,
  output result_t    res
);

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic               header_ok, header_ok_next;
  logic               trailer_ok, trailer_ok_next;
  logic [LEN_W-1:0]   declared_length, declared_length_next;
  logic [7:0]         pending_x, pending_x_next;
  logic [7:0]         staged_x, staged_x_next;
  logic [7:0]         staged_y, staged_y_next;
  logic               staged_valid, staged_valid_next;
  logic [7:0]         held_x, held_x_next;
  logic [7:0]         held_y, held_y_next;

  logic [COUNT_W-1:0] len_ext, len_ext_next;
  logic [COUNT_W-1:0] tail_off;
  logic               in_payload, in_trailer;
  status_t            status;

  assign len_ext    = {1'b0, declared_length};
  assign in_payload = (declared_length != '0) && (byte_count <= len_ext + COUNT_W'(4));
  assign in_trailer = (byte_count >= len_ext + COUNT_W'(6)) &&
                      (byte_count <= len_ext + COUNT_W'(8));
  assign tail_off   = byte_count - (len_ext + COUNT_W'(6));
  assign len_ext_next = {1'b0, declared_length_next};

  always_comb begin
    byte_count_next      = byte_count;
    header_ok_next       = header_ok;
    trailer_ok_next      = trailer_ok;
    declared_length_next = declared_length;
    pending_x_next       = pending_x;
    staged_x_next        = staged_x;
    staged_y_next        = staged_y;
    staged_valid_next    = staged_valid;
    held_x_next          = held_x;
    held_y_next          = held_y;
    status               = STATUS_OK;

    if (take) begin
      if (byte_count < COUNT_W'(3)) begin
        if (rx_byte != HEAD_BYTES[byte_count[1:0]]) header_ok_next = 1'b0;
      end else if (byte_count == COUNT_W'(3)) begin
        declared_length_next = {rx_byte, 8'h00};
      end else if (byte_count == COUNT_W'(4)) begin
        declared_length_next = {declared_length[15:8], rx_byte};
      end else if (byte_count >= COUNT_W'(6)) begin
        if (in_payload) begin
          // payload starts on an even count, so bit 0 picks x or y
          if (!byte_count[0]) begin
            pending_x_next = rx_byte;
          end else begin
            staged_x_next     = pending_x;
            staged_y_next     = rx_byte;
            staged_valid_next = 1'b1;
          end
        end else if (in_trailer) begin
          if (rx_byte != TAIL_BYTES[tail_off[1:0]]) trailer_ok_next = 1'b0;
        end
      end

      if (byte_count != COUNT_MAX) byte_count_next = byte_count + COUNT_W'(1);

      if (line_end) begin
        if (!header_ok_next || byte_count_next < COUNT_W'(3)) begin
          status = BAD_HEADER;
        end else if (byte_count_next < COUNT_W'(5) || declared_length_next == '0 ||
                     byte_count_next != len_ext_next + COUNT_W'(9)) begin
          status = BAD_LENGTH;
        end else if (!trailer_ok_next) begin
          status = BAD_TRAILER;
        end else begin
          status = STATUS_OK;
          if (staged_valid_next) begin
            held_x_next = staged_x_next;
            held_y_next = staged_y_next;
          end
        end

        // fresh line
        byte_count_next      = '0;
        header_ok_next       = 1'b1;
        trailer_ok_next      = 1'b1;
        declared_length_next = '0;
        pending_x_next       = '0;
        staged_x_next        = '0;
        staged_y_next        = '0;
        staged_valid_next    = 1'b0;
      end
    end
  end

  assign fire             = take && line_end;
  assign res.pos_x        = held_x_next;
  assign res.pos_y        = held_y_next;
  assign res.frame_status = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      header_ok       <= 1'b1;
      trailer_ok      <= 1'b1;
      declared_length <= '0;
      pending_x       <= '0;
      staged_x        <= '0;
      staged_y        <= '0;
      staged_valid    <= 1'b0;
      held_x          <= '0;
      held_y          <= '0;
    end else begin
      byte_count      <= byte_count_next;
      header_ok       <= header_ok_next;
      trailer_ok      <= trailer_ok_next;
      declared_length <= declared_length_next;
      pending_x       <= pending_x_next;
      staged_x        <= staged_x_next;
      staged_y        <= staged_y_next;
      staged_valid    <= staged_valid_next;
      held_x          <= held_x_next;
      held_y          <= held_y_next;
    end
  end

endmodule

// File: rtl/rfp_obuf.sv
// ----------------------------------------------------------------------------
// rfp_obuf - result output buffer
// Output register with one skid entry so bytes keep flowing while a result
// waits downstream.
// ----------------------------------------------------------------------------
module rfp_obuf import rfp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  result_t          data,
  output logic             has_room,
  rfp_out_if.source        res
);

  logic    out_valid, skid_valid;
  result_t out_data, skid_data;
  logic    out_free;

  assign out_free = !out_valid || res.ready;
  assign has_room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_free) begin
      if (push) skid_valid <= 1'b1;
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= push;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (!out_free) begin
      if (push) skid_data <= data;
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (push) begin
      out_data <= data;
    end
  end

  assign res.valid        = out_valid;
  assign res.pos_x        = out_data.pos_x;
  assign res.pos_y        = out_data.pos_y;
  assign res.frame_status = out_data.frame_status;

endmodule

// File: rtl/radar_frame_parser_top.sv
// ----------------------------------------------------------------------------
// radar_frame_parser_top - serial radar frame parser
// Checks each received line as one framed packet and reports the held
// position with a frame status at every line end.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle while the skid entry of
// the output buffer is free, with no gaps between frames or lines; the rate
// is set by the update of the 17-bit byte counter and the delimiter and length
// compares in rfp_core. A frame is FF EE DD, a big-endian 16-bit length L,
// one skipped byte, L-1 payload bytes of signed x,y pairs, one unchecked byte
// and DD EE FF. The byte flagged as line end yields one result word, registered
// in the output buffer: status 0 ok, 1 bad header, 2 bad length, 3 bad trailer,
// plus the held position, which an ok frame loads from its last complete pair.
// A two-entry output buffer lets input bytes keep arriving while a result
// waits; input ready drops only when both entries are full.
module radar_frame_parser_top import rfp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rfp_in_if.sink    rx,
  rfp_out_if.source res
);

  logic    rx_take;
  logic    buf_room;
  logic    res_fire;
  result_t res_word;

  // byte taken whenever the skid entry is free
  assign rx.ready = buf_room;
  assign rx_take  = rx.valid && buf_room;

  rfp_core u_core (
    .clk      (clk),
    .rst      (rst),
    .take     (rx_take),
    .rx_byte  (rx.rx_byte),
    .line_end (rx.line_end),
    .fire     (res_fire),
    .res      (res_word)
  );

  // result word registered on the way out
  rfp_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .push     (res_fire),
    .data     (res_word),
    .has_room (buf_room),
    .res      (res)
  );

endmodule

// File: tb/radar_frame_parser_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radar_frame_parser_top_test - self-checking bench for the frame parser
// Feeds received bytes as words on the input channel and checks each result
// word at a line end. The bench keeps its own copy of the line state.
// ----------------------------------------------------------------------------
module radar_frame_parser_top_test;
  import rfp_pkg::*;

  // generous ceiling, far above the slowest run with every stall taken
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  // number of mismatches that get a printed line
  localparam int REPORT_MAX = 10;

  // ways of spoiling a random frame
  typedef enum int {
    FAULT_NONE,
    FAULT_HEAD,
    FAULT_TAIL,
    FAULT_SHORT,
    FAULT_LONG,
    FAULT_ZERO,
    FAULT_NOISE
  } frame_fault_t;

  // one row of the opening table; known marks a hand-written result
  typedef struct packed {
    logic [7:0]        data;
    logic              last;
    logic              known;
    status_t           st;
    logic signed [7:0] x;
    logic signed [7:0] y;
  } frame_row_t;

  logic clk;
  logic rst;

  rfp_in_if  byte_ch ();
  rfp_out_if frame_ch ();

  radar_frame_parser_top uut (
    .clk (clk),
    .rst (rst),
    .rx  (byte_ch),
    .res (frame_ch)
  );

  // ---------------------------------------------------------------------------
  // opening table: after-reset results, short lines, zero length, extremes
  // ---------------------------------------------------------------------------
  frame_row_t opening_rows [24] = '{
    // lone byte straight after reset: bad header, held position still zero
    '{8'h00, 1'b1, 1'b1, BAD_HEADER,  8'sh00, 8'sh00},
    // two header bytes then line end: too short for a header
    '{8'hFF, 1'b0, 1'b0, STATUS_OK,   8'sh00, 8'sh00},
    '{8'hEE, 1'b1, 1'b1, BAD_HEADER,  8'sh00, 8'sh00},
    // good header, one length byte only: bad length
    '{8'hFF, 1'b0, 1'b0, STATUS_OK,   8'sh00, 8'sh00},
    '{8'hEE, 1'b0, 1'b0, STATUS_OK,   8'sh00, 8'sh00},
    '{8'hDD, 1'b0, 1'b0, STATUS_OK,   8'sh00, 8'sh00},
    '{8'h00, 1'b1, 1'b1, BAD_LENGTH,  8'sh00, 8'sh00},
    // declared length of zero
    '{8'hFF, 1'b0, 1'b0, STATUS_OK,   8'sh00, 8'sh00},
    '{8'hEE, 1'b0, 1'b0, STATUS_OK,   8'sh00, 8'sh00},
    '{8'hDD, 1'b0, 1'b0, STATUS_OK,   8'sh00, 8'sh00},
    '{8'h00, 1'b0, 1'b0, STATUS_OK,   8'sh00, 8'sh00},
    '{8'h00, 1'b1, 1'b1, BAD_LENGTH,  8'sh00, 8'sh00},
    // clean frame, length 3, one pair at the signed extremes
    '{8'hFF, 1'b0, 1'b0, STATUS_OK,   8'sh00, 8'sh00},
    '{8'hEE, 1'b0, 1'b0, STATUS_OK,   8'sh00, 8'sh00},
    '{8'hDD, 1'b0, 1'b0, STATUS_OK,   8'sh00, 8'sh00},
    '{8'h00, 1'b0, 1'b0, STATUS_OK,   8'sh00, 8'sh00},
    '{8'h03, 1'b0, 1'b0, STATUS_OK,   8'sh00, 8'sh00},
    '{8'hA5, 1'b0, 1'b0, STATUS_OK,   8'sh00, 8'sh00},
    '{8'h7F, 1'b0, 1'b0, STATUS_OK,   8'sh00, 8'sh00},
    '{8'h80, 1'b0, 1'b0, STATUS_OK,   8'sh00, 8'sh00},
    '{8'h5A, 1'b0, 1'b0, STATUS_OK,   8'sh00, 8'sh00},
    '{8'hDD, 1'b0, 1'b0, STATUS_OK,   8'sh00, 8'sh00},
    '{8'hEE, 1'b0, 1'b0, STATUS_OK,   8'sh00, 8'sh00},
    '{8'hFF, 1'b1, 1'b1, STATUS_OK,   8'sh7F, 8'sh80}
  };

  // ---------------------------------------------------------------------------
  // line state mirrored by the bench
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] line_cnt  = '0;
  logic               head_good = 1'b1;
  logic               tail_good = 1'b1;
  logic [LEN_W-1:0]   len_field = '0;
  logic signed [7:0]  pend_x    = '0;
  logic signed [7:0]  pair_x    = '0;
  logic signed [7:0]  pair_y    = '0;
  logic               pair_seen = 1'b0;
  logic signed [7:0]  held_x    = '0;
  logic signed [7:0]  held_y    = '0;

  result_t     due_results [$];   // result words still to come, oldest first
  int          fault_count = 0;
  int          bytes_taken = 0;   // input words accepted so far
  bit          quiet       = 1'b0;
  bit          stall_arm   = 1'b0;
  bit          hold_off    = 1'b0;
  int unsigned cycle_count = 0;

  // ---------------------------------------------------------------------------
  // clock and cycle ceiling
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // line parser, one received byte at a time
  // ---------------------------------------------------------------------------
  function automatic void restart_line();
    line_cnt  = '0;
    head_good = 1'b1;
    tail_good = 1'b1;
    len_field = '0;
    pend_x    = '0;
    pair_x    = '0;
    pair_y    = '0;
    pair_seen = 1'b0;
  endfunction

  // returns 1 when the byte closes a line, with the result word it gives
  function automatic bit parse_byte(input logic [7:0] data, input logic last,
                                    output result_t outcome);
    int idx;
    int len;
    int total;
    idx     = int'(line_cnt);
    len     = int'(len_field);
    outcome = '0;
    if (idx < 3) begin
      if (data != HEAD_BYTES[idx]) head_good = 1'b0;
    end else if (idx == 3) begin
      // high byte first, low half cleared until the next byte
      len_field = {data, 8'h00};
    end else if (idx == 4) begin
      len_field[7:0] = data;
    end else if (idx >= 6) begin
      // payload runs up to index len+4; a lone last byte never pairs up
      if (len >= 1 && idx <= len + 4) begin
        if ((idx - 6) % 2 == 0) begin
          pend_x = data;
        end else begin
          pair_x    = pend_x;
          pair_y    = data;
          pair_seen = 1'b1;
        end
      end else if (idx >= len + 6 && idx <= len + 8) begin
        if (data != TAIL_BYTES[idx - len - 6]) tail_good = 1'b0;
      end
    end
    // counter sticks at its top value on very long lines
    if (line_cnt != COUNT_MAX) line_cnt++;
    if (!last) return 1'b0;

    total = int'(line_cnt);
    len   = int'(len_field);
    if (!head_good || total < 3) begin
      outcome.frame_status = BAD_HEADER;
    end else if (total < 5 || len == 0 || total != len + 9) begin
      outcome.frame_status = BAD_LENGTH;
    end else if (!tail_good) begin
      outcome.frame_status = BAD_TRAILER;
    end else begin
      outcome.frame_status = STATUS_OK;
      // a good frame without a whole pair keeps the old position
      if (pair_seen) begin
        held_x = pair_x;
        held_y = pair_y;
      end
    end
    outcome.pos_x = held_x;
    outcome.pos_y = held_y;
    restart_line();
    return 1'b1;
  endfunction

  function automatic void flag_fault(input string msg);
    fault_count++;
    if (fault_count <= REPORT_MAX) $display("%s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // input side: one word per call, with random idle bursts ahead of it
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] data, input logic last,
                           input logic known, input result_t typed);
    result_t got;
    bit      fired;
    if (!quiet && $urandom_range(0, 99) < 15) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    byte_ch.valid    <= 1'b1;
    byte_ch.rx_byte  <= data;
    byte_ch.line_end <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    // word taken at this edge
    bytes_taken++;
    fired = parse_byte(data, last, got);
    if (fired) due_results = {due_results, (known ? typed : got)};
  endtask

  // builds a whole line, well formed unless a fault is asked for
  task automatic send_frame(input int len, input frame_fault_t fault, input int extra);
    logic [7:0] line_q [$];
    int         keep;
    int         spot;
    result_t    blank;
    blank = '0;
    if (fault == FAULT_ZERO) len = 0;
    if (fault == FAULT_NOISE) begin
      repeat ($urandom_range(1, 12)) line_q = {line_q, 8'($urandom)};
    end else begin
      for (int i = 0; i < 3; i++) line_q = {line_q, HEAD_BYTES[i]};
      line_q = {line_q, 8'(len >> 8)};
      line_q = {line_q, 8'(len)};
      line_q = {line_q, 8'($urandom)};             // skipped byte
      for (int i = 1; i < len; i++) line_q = {line_q, 8'($urandom)};
      line_q = {line_q, 8'($urandom)};             // unchecked byte
      for (int i = 0; i < 3; i++) line_q = {line_q, TAIL_BYTES[i]};
    end

    case (fault)
      FAULT_HEAD: begin
        spot = $urandom_range(0, 2);
        line_q[spot] = line_q[spot] ^ 8'($urandom_range(1, 255));
      end
      FAULT_TAIL: begin
        spot = line_q.size() - 1 - $urandom_range(0, 2);
        line_q[spot] = line_q[spot] ^ 8'($urandom_range(1, 255));
      end
      FAULT_SHORT: begin
        // now and then cut right down into the header or length field
        if ($urandom_range(0, 3) == 0) keep = $urandom_range(1, 4);
        else keep = line_q.size() - $urandom_range(1, 4);
        while (line_q.size() > keep) void'(line_q.pop_back());
      end
      FAULT_LONG: begin
        repeat (extra) line_q = {line_q, 8'($urandom)};
      end
      default: ;
    endcase

    foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1, 1'b0, blank);
  endtask

  // mostly clean short frames, the rest spoilt in one way or another
  task automatic send_random_frame();
    int           pick;
    int           len;
    frame_fault_t fault;
    pick = $urandom_range(0, 99);
    if (pick < 55)      fault = FAULT_NONE;
    else if (pick < 63) fault = FAULT_HEAD;
    else if (pick < 71) fault = FAULT_TAIL;
    else if (pick < 79) fault = FAULT_SHORT;
    else if (pick < 86) fault = FAULT_LONG;
    else if (pick < 90) fault = FAULT_ZERO;
    else                fault = FAULT_NOISE;
    if ($urandom_range(0, 9) == 0) len = $urandom_range(17, 300);
    else len = $urandom_range(1, 16);
    send_frame(len, fault, $urandom_range(1, 4));
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready with random bursts, plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_ready
    int idle_left;
    idle_left = 0;
    frame_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        frame_ch.ready <= 1'b0;
      end else if (idle_left > 0) begin
        frame_ch.ready <= 1'b0;
        idle_left--;
      end else if (!quiet && $urandom_range(0, 99) < 15) begin
        idle_left = $urandom_range(0, 4);
        frame_ch.ready <= 1'b0;
      end else begin
        frame_ch.ready <= 1'b1;
      end
    end
  end

  // long hold-off so the output buffer fills and input ready drops
  initial begin : long_hold
    wait (stall_arm);
    repeat (150) @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // each accepted result word against the oldest one due
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && frame_ch.valid && frame_ch.ready) begin
      if (due_results.size() == 0) begin
        flag_fault($sformatf("unexpected result word: x %0d y %0d status %0d",
                             frame_ch.pos_x, frame_ch.pos_y, frame_ch.frame_status));
      end else begin
        want = due_results.pop_front();
        if (frame_ch.pos_x !== want.pos_x || frame_ch.pos_y !== want.pos_y ||
            frame_ch.frame_status !== want.frame_status) begin
          flag_fault($sformatf(
            "result mismatch: expected x %0d y %0d status %0d, got x %0d y %0d status %0d",
            $signed(want.pos_x), $signed(want.pos_y), want.frame_status,
            frame_ch.pos_x, frame_ch.pos_y, frame_ch.frame_status));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    result_t typed;
    int      mark;
    rst              <= 1'b1;
    byte_ch.valid    <= 1'b0;
    byte_ch.rx_byte  <= 8'h00;
    byte_ch.line_end <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // opening table, hand-written results where they are obvious
    foreach (opening_rows[i]) begin
      typed.pos_x        = opening_rows[i].x;
      typed.pos_y        = opening_rows[i].y;
      typed.frame_status = opening_rows[i].st;
      send_byte(opening_rows[i].data, opening_rows[i].last, opening_rows[i].known, typed);
    end

    // random frames; the long hold-off lands somewhere in here
    stall_arm = 1'b1;
    while (bytes_taken < 1080) send_random_frame();

    // closing stretch at full rate on both sides
    quiet = 1'b1;
    mark  = bytes_taken;
    while (bytes_taken < mark + 200) send_random_frame();
    byte_ch.valid <= 1'b0;

    // drain, then a short settle to catch stray result words
    while (due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
